/* sv/idr_pkg.sv */
package idr_pkg;

  localparam int DIV_W = 38;
  // ceil(2^42 / 125); the dividend is shifted right by 3 first, which leaves a divide by 125
  localparam logic [35:0] RECIP_125 = 36'd35184372089;
  localparam int RECIP_SHIFT = 24;

  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;
  localparam int G_Q16 = 642689;
  localparam int GYRO_SQ_K = 1308322;
  localparam int DT_MIN = 5;
  localparam int DT_MAX = 50;
  localparam int K_ONE = 65536;

  localparam logic [14:0] RST_ACC_LOW = 15'd3686;
  localparam logic [14:0] RST_ACC_HIGH = 15'd4506;
  localparam logic [14:0] RST_GYRO_LIM = 15'd819;
  localparam logic [7:0] RST_QUIET_FRAMES = 8'd30;
  localparam logic [15:0] RST_BIAS_GAIN = 16'd1311;
  localparam logic [15:0] RST_LEAK_RATE = 16'd768;

  typedef enum logic [2:0] {
    REG_ACC_LOW      = 3'd0,
    REG_ACC_HIGH     = 3'd1,
    REG_GYRO_LIM     = 3'd2,
    REG_QUIET_FRAMES = 3'd3,
    REG_BIAS_GAIN    = 3'd4,
    REG_LEAK_RATE    = 3'd5
  } reg_e;

  typedef struct packed {
    logic [15:0]        elapsed_ms;
    logic signed [15:0] acc_fwd;
    logic signed [15:0] acc_left;
    logic signed [15:0] acc_up;
    logic signed [15:0] rate_a;
    logic signed [15:0] rate_b;
    logic signed [15:0] rate_c;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               is_still;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [15:0] data;
  } cfg_item_t;

  // datapath micro-operations, issued in this order except at OP_BR
  typedef enum logic [5:0] {
    OP_NOP,
    OP_R0A, OP_R0B, OP_R0C, OP_R1A, OP_R1B, OP_R1C, OP_R2A, OP_R2B, OP_R2C,
    OP_XQ, OP_XG,
    OP_R3A, OP_R3B, OP_R3C, OP_R4A, OP_R4B, OP_R4C, OP_R5A, OP_R5B, OP_R5C,
    OP_YQ, OP_YG,
    OP_SA0, OP_SA1, OP_SA2, OP_SG0, OP_SG1, OP_SG2,
    OP_LO, OP_HI, OP_GL, OP_GK, OP_QUIET, OP_BR,
    OP_BX, OP_BY, OP_LK, OP_LKW, OP_VKX, OP_VKY,
    OP_TVX, OP_TVXW, OP_TVY, OP_TVYW, OP_TPX, OP_TPXW, OP_TPY, OP_TPYW
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic still;
    logic div_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

/* sv/idr_stream_if.sv */
interface idr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/idr_div.sv */
module idr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [idr_pkg::DIV_W-1:0]  dividend_i,
  output logic                       busy_o,
  output logic [idr_pkg::DIV_W-1:0]  quot_o
);
  logic [34:0]               num_q;
  logic [35:0]               part_q;
  logic                      phase_q;
  logic                      busy_q;
  logic [idr_pkg::DIV_W-1:0] quot_q;
  logic [17:0]               half;
  logic [53:0]               prod;
  logic [53:0]               sum;

  // divide by 8, then multiply by the reciprocal of 125:
  // low half of the dividend in phase 0, high half in phase 1
  assign half = phase_q ? {1'b0, num_q[34:18]} : num_q[17:0];
  assign prod = 54'(half) * 54'(idr_pkg::RECIP_125);
  assign sum = prod + 54'(part_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      phase_q <= 1'b0;
      num_q <= '0;
      part_q <= '0;
      quot_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      phase_q <= 1'b0;
      num_q <= dividend_i[idr_pkg::DIV_W-1:3];
    end else if (busy_q) begin
      if (!phase_q) begin
        part_q <= 36'(prod >> 18);
        phase_q <= 1'b1;
      end else begin
        quot_q <= idr_pkg::DIV_W'(sum >> idr_pkg::RECIP_SHIFT);
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

/* sv/idr_ctrl.sv */
module idr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  idr_pkg::status_t status_i,
  output idr_pkg::cmd_t    cmd_o
);
  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_e;

  state_e         state_q;
  idr_pkg::op_e   op_q;
  logic           out_valid_q;
  logic           wb_op;
  logic           out_free;

  // writeback steps wait for the divider
  assign wb_op = op_q inside {idr_pkg::OP_LKW, idr_pkg::OP_TVXW, idr_pkg::OP_TVYW,
                              idr_pkg::OP_TPXW, idr_pkg::OP_TPYW};
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= idr_pkg::OP_NOP;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_RUN;
            op_q <= idr_pkg::OP_R0A;
          end
        end
        ST_RUN: begin
          if (wb_op && status_i.div_busy) begin
            op_q <= op_q;
          end else if (op_q == idr_pkg::OP_TPYW) begin
            state_q <= ST_OUT;
            op_q <= idr_pkg::OP_NOP;
          end else if (op_q == idr_pkg::OP_BR) begin
            op_q <= status_i.still ? idr_pkg::OP_BX : idr_pkg::OP_TVX;
          end else begin
            op_q <= idr_pkg::op_e'(6'(op_q) + 6'd1);
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign cmd_o.op = op_q;
  assign cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.out_load = (state_q == ST_OUT) && out_free;
endmodule

/* sv/idr_dp.sv */
module idr_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  idr_pkg::cmd_t      cmd_i,
  output idr_pkg::status_t   status_o,
  input  idr_pkg::in_item_t  in_item_i,
  output idr_pkg::out_item_t out_item_o,
  input  logic               cfg_wr_i,
  input  idr_pkg::cfg_item_t cfg_item_i
);
  logic [14:0] acc_low_q, acc_high_q, gyro_lim_q;
  logic [7:0]  quiet_frames_q;
  logic [15:0] bias_gain_q, leak_rate_q;

  idr_pkg::in_item_t  in_q;
  idr_pkg::out_item_t out_q;
  logic [5:0]         dt_q;
  logic signed [35:0] acc_q;
  logic signed [34:0] rr_q;
  logic signed [51:0] sum_q;
  logic signed [37:0] axq_q;
  logic signed [31:0] ax_q, ay_q;
  logic [33:0]        sa_q;
  logic [32:0]        sg_q;
  logic [29:0]        gl_q;
  logic               lo_ok_q, hi_ok_q, gyro_ok_q, neg_q;
  logic [16:0]        k_q;
  logic [7:0]         count_q;
  logic               still_q;
  logic signed [31:0] bias_x_q, bias_y_q, vel_x_q, vel_y_q, pos_x_q, pos_y_q;

  logic signed [37:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [59:0] prod;
  logic signed [63:0] prod_w, acc_w, pabs_w, sq_w;
  logic               div_start, div_busy;
  logic [idr_pkg::DIV_W-1:0] div_num, quot;
  logic               quiet;
  logic [7:0]         count_d;

  idr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      idr_pkg::OP_R0A: begin mul_a = 38'(in_q.quat_y); mul_b = 22'(in_q.quat_y); end
      idr_pkg::OP_R0B, idr_pkg::OP_R4B: begin
        mul_a = 38'(in_q.quat_z); mul_b = 22'(in_q.quat_z);
      end
      idr_pkg::OP_R1A, idr_pkg::OP_R3A: begin
        mul_a = 38'(in_q.quat_x); mul_b = 22'(in_q.quat_y);
      end
      idr_pkg::OP_R1B, idr_pkg::OP_R3B: begin
        mul_a = 38'(in_q.quat_w); mul_b = 22'(in_q.quat_z);
      end
      idr_pkg::OP_R2A: begin mul_a = 38'(in_q.quat_x); mul_b = 22'(in_q.quat_z); end
      idr_pkg::OP_R2B: begin mul_a = 38'(in_q.quat_w); mul_b = 22'(in_q.quat_y); end
      idr_pkg::OP_R4A: begin mul_a = 38'(in_q.quat_x); mul_b = 22'(in_q.quat_x); end
      idr_pkg::OP_R5A: begin mul_a = 38'(in_q.quat_y); mul_b = 22'(in_q.quat_z); end
      idr_pkg::OP_R5B: begin mul_a = 38'(in_q.quat_w); mul_b = 22'(in_q.quat_x); end
      idr_pkg::OP_R0C, idr_pkg::OP_R3C: begin mul_a = 38'(rr_q); mul_b = 22'(in_q.acc_fwd); end
      idr_pkg::OP_R1C, idr_pkg::OP_R4C: begin mul_a = 38'(rr_q); mul_b = 22'(in_q.acc_left); end
      idr_pkg::OP_R2C, idr_pkg::OP_R5C: begin mul_a = 38'(rr_q); mul_b = 22'(in_q.acc_up); end
      idr_pkg::OP_XG, idr_pkg::OP_YG: begin
        mul_a = axq_q; mul_b = signed'(22'(idr_pkg::G_Q16));
      end
      idr_pkg::OP_SA0: begin mul_a = 38'(in_q.acc_fwd); mul_b = 22'(in_q.acc_fwd); end
      idr_pkg::OP_SA1: begin mul_a = 38'(in_q.acc_left); mul_b = 22'(in_q.acc_left); end
      idr_pkg::OP_SA2: begin mul_a = 38'(in_q.acc_up); mul_b = 22'(in_q.acc_up); end
      idr_pkg::OP_SG0: begin mul_a = 38'(in_q.rate_a); mul_b = 22'(in_q.rate_a); end
      idr_pkg::OP_SG1: begin mul_a = 38'(in_q.rate_b); mul_b = 22'(in_q.rate_b); end
      idr_pkg::OP_SG2: begin mul_a = 38'(in_q.rate_c); mul_b = 22'(in_q.rate_c); end
      idr_pkg::OP_LO: begin mul_a = signed'(38'(acc_low_q)); mul_b = signed'(22'(acc_low_q)); end
      idr_pkg::OP_HI: begin
        mul_a = signed'(38'(acc_high_q)); mul_b = signed'(22'(acc_high_q));
      end
      idr_pkg::OP_GL: begin
        mul_a = signed'(38'(gyro_lim_q)); mul_b = signed'(22'(gyro_lim_q));
      end
      idr_pkg::OP_GK: begin
        mul_a = signed'(38'(sg_q)); mul_b = signed'(22'(idr_pkg::GYRO_SQ_K));
      end
      idr_pkg::OP_BX: begin
        mul_a = 38'(64'(ax_q) - 64'(bias_x_q)); mul_b = signed'(22'(bias_gain_q));
      end
      idr_pkg::OP_BY: begin
        mul_a = 38'(64'(ay_q) - 64'(bias_y_q)); mul_b = signed'(22'(bias_gain_q));
      end
      idr_pkg::OP_LK: begin mul_a = signed'(38'(leak_rate_q)); mul_b = signed'(22'(dt_q)); end
      idr_pkg::OP_VKX: begin mul_a = 38'(vel_x_q); mul_b = signed'(22'(k_q)); end
      idr_pkg::OP_VKY: begin mul_a = 38'(vel_y_q); mul_b = signed'(22'(k_q)); end
      idr_pkg::OP_TVX: begin
        mul_a = 38'(64'(ax_q) - 64'(bias_x_q)); mul_b = signed'(22'(dt_q));
      end
      idr_pkg::OP_TVY: begin
        mul_a = 38'(64'(ay_q) - 64'(bias_y_q)); mul_b = signed'(22'(dt_q));
      end
      idr_pkg::OP_TPX: begin mul_a = 38'(vel_x_q); mul_b = signed'(22'(dt_q)); end
      idr_pkg::OP_TPY: begin mul_a = 38'(vel_y_q); mul_b = signed'(22'(dt_q)); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign prod_w = 64'(prod);
  assign acc_w = 64'(acc_q);
  assign pabs_w = (prod_w < 0) ? -prod_w : prod_w;
  assign sq_w = neg_q ? -signed'(64'(quot)) : signed'(64'(quot));

  // divide by 1000: time products round half away from zero
  assign div_start = cmd_i.op inside {idr_pkg::OP_LK, idr_pkg::OP_TVX, idr_pkg::OP_TVY,
                                      idr_pkg::OP_TPX, idr_pkg::OP_TPY};
  assign div_num = (cmd_i.op == idr_pkg::OP_LK) ? idr_pkg::DIV_W'((prod_w <<< 8) + 64'sd500)
                                                : idr_pkg::DIV_W'(pabs_w + 64'sd500);

  assign quiet = lo_ok_q && hi_ok_q && gyro_ok_q;
  always_comb begin
    if (!quiet) begin
      count_d = '0;
    end else if (count_q < quiet_frames_q) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  // configuration and navigation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_low_q <= idr_pkg::RST_ACC_LOW;
      acc_high_q <= idr_pkg::RST_ACC_HIGH;
      gyro_lim_q <= idr_pkg::RST_GYRO_LIM;
      quiet_frames_q <= idr_pkg::RST_QUIET_FRAMES;
      bias_gain_q <= idr_pkg::RST_BIAS_GAIN;
      leak_rate_q <= idr_pkg::RST_LEAK_RATE;
      count_q <= '0;
      still_q <= 1'b0;
      bias_x_q <= '0;
      bias_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else begin
      if (cfg_wr_i) begin
        case (cfg_item_i.addr)
          idr_pkg::REG_ACC_LOW:      acc_low_q <= cfg_item_i.data[14:0];
          idr_pkg::REG_ACC_HIGH:     acc_high_q <= cfg_item_i.data[14:0];
          idr_pkg::REG_GYRO_LIM:     gyro_lim_q <= cfg_item_i.data[14:0];
          idr_pkg::REG_QUIET_FRAMES: quiet_frames_q <= cfg_item_i.data[7:0];
          idr_pkg::REG_BIAS_GAIN:    bias_gain_q <= cfg_item_i.data;
          idr_pkg::REG_LEAK_RATE:    leak_rate_q <= cfg_item_i.data;
          default: ;
        endcase
      end
      case (cmd_i.op)
        idr_pkg::OP_QUIET: begin
          count_q <= count_d;
          still_q <= count_d >= quiet_frames_q;
        end
        idr_pkg::OP_BX:
          bias_x_q <= idr_pkg::sat32(64'(bias_x_q) + ((prod_w + 64'sd32768) >>> 16));
        idr_pkg::OP_BY:
          bias_y_q <= idr_pkg::sat32(64'(bias_y_q) + ((prod_w + 64'sd32768) >>> 16));
        idr_pkg::OP_VKX: vel_x_q <= idr_pkg::sat32((prod_w + 64'sd32768) >>> 16);
        idr_pkg::OP_VKY: vel_y_q <= idr_pkg::sat32((prod_w + 64'sd32768) >>> 16);
        idr_pkg::OP_TVXW: if (!div_busy) vel_x_q <= idr_pkg::sat32(64'(vel_x_q) - sq_w);
        idr_pkg::OP_TVYW: if (!div_busy) vel_y_q <= idr_pkg::sat32(64'(vel_y_q) + sq_w);
        idr_pkg::OP_TPXW: if (!div_busy) pos_x_q <= idr_pkg::sat32(64'(pos_x_q) - sq_w);
        idr_pkg::OP_TPYW: if (!div_busy) pos_y_q <= idr_pkg::sat32(64'(pos_y_q) + sq_w);
        default: ;
      endcase
    end
  end

  // per-sample working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_item_i;
      if (in_item_i.elapsed_ms == '0) begin
        dt_q <= 6'(idr_pkg::DT_MIN);
      end else if (in_item_i.elapsed_ms > 16'(idr_pkg::DT_MAX)) begin
        dt_q <= 6'(idr_pkg::DT_MAX);
      end else begin
        dt_q <= in_item_i.elapsed_ms[5:0];
      end
    end
    if (cmd_i.out_load) begin
      out_q <= '{pos_x: pos_x_q, pos_y: pos_y_q, vel_x: vel_x_q, vel_y: vel_y_q,
                 is_still: still_q};
    end
    case (cmd_i.op)
      idr_pkg::OP_R0A, idr_pkg::OP_R1A, idr_pkg::OP_R2A, idr_pkg::OP_R3A,
      idr_pkg::OP_R4A, idr_pkg::OP_R5A, idr_pkg::OP_SA0, idr_pkg::OP_SG0:
        acc_q <= 36'(prod_w);
      idr_pkg::OP_SA1, idr_pkg::OP_SG1: acc_q <= 36'(acc_w + prod_w);
      idr_pkg::OP_R0B, idr_pkg::OP_R4B:
        rr_q <= 35'(idr_pkg::ONE_Q28 - ((acc_w + prod_w) <<< 1));
      idr_pkg::OP_R1B, idr_pkg::OP_R5B: rr_q <= 35'((acc_w - prod_w) <<< 1);
      idr_pkg::OP_R2B, idr_pkg::OP_R3B: rr_q <= 35'((acc_w + prod_w) <<< 1);
      idr_pkg::OP_R0C, idr_pkg::OP_R3C: sum_q <= 52'(prod_w);
      idr_pkg::OP_R1C, idr_pkg::OP_R2C, idr_pkg::OP_R4C, idr_pkg::OP_R5C:
        sum_q <= 52'(64'(sum_q) + prod_w);
      idr_pkg::OP_XQ, idr_pkg::OP_YQ: axq_q <= 38'((64'(sum_q) + 64'sd32768) >>> 16);
      idr_pkg::OP_XG: ax_q <= idr_pkg::sat32((prod_w + 64'sd8388608) >>> 24);
      idr_pkg::OP_YG: ay_q <= idr_pkg::sat32((prod_w + 64'sd8388608) >>> 24);
      idr_pkg::OP_SA2: sa_q <= 34'(acc_w + prod_w);
      idr_pkg::OP_SG2: sg_q <= 33'(acc_w + prod_w);
      idr_pkg::OP_LO: lo_ok_q <= signed'(64'(sa_q)) > prod_w;
      idr_pkg::OP_HI: hi_ok_q <= signed'(64'(sa_q)) < prod_w;
      idr_pkg::OP_GL: gl_q <= 30'(prod_w);
      idr_pkg::OP_GK: gyro_ok_q <= prod_w < (signed'(64'(gl_q)) <<< 16);
      idr_pkg::OP_LK: neg_q <= 1'b0;
      idr_pkg::OP_TVX, idr_pkg::OP_TVY, idr_pkg::OP_TPX, idr_pkg::OP_TPY:
        neg_q <= prod_w < 0;
      idr_pkg::OP_LKW: begin
        if (!div_busy) begin
          k_q <= (quot > idr_pkg::DIV_W'(idr_pkg::K_ONE)) ? 17'd0
                 : 17'(idr_pkg::DIV_W'(idr_pkg::K_ONE) - quot);
        end
      end
      default: ;
    endcase
  end

  assign status_o.still = still_q;
  assign status_o.div_busy = div_busy;
  assign out_item_o = out_q;
endmodule

/* sv/imu_dead_reckoning_zupt.sv */
// channel   dir  port   payload               transaction
// input     in   in_i   idr_pkg::in_item_t    valid && ready, one imu sample
// result    out  out_o  idr_pkg::out_item_t   valid && ready, one nav state
// config    in   cfg_i  idr_pkg::cfg_item_t   valid && ready, one register write
//
// a result becomes valid in the same cycle that the input channel turns ready for the next
// sample. the shared multiplier runs one step per cycle, but a writeback step waits for
// each divide by 1000 (four per sample, five when stationary) to end its reciprocal multiply.
// rst_ni clears the navigation state and loads the register defaults.
// a finished result waits in the output register; a new sample is taken meanwhile and
// holds in its last step until the output register frees up. config writes are always taken.
module imu_dead_reckoning_zupt (
  input  logic         clk_i,
  input  logic         rst_ni,
  idr_stream_if.sink   in_i,
  idr_stream_if.source out_o,
  idr_stream_if.sink   cfg_i
);
  idr_pkg::cmd_t    cmd;
  idr_pkg::status_t status;
  logic             in_ready;
  logic             out_valid;

  idr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  idr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_i.payload),
    .out_item_o (out_o.payload),
    .cfg_wr_i   (cfg_i.valid),
    .cfg_item_i (cfg_i.payload)
  );

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;
endmodule

/* sv/idr_chk.sv */
module idr_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input idr_pkg::out_item_t out_payload_i,
  input logic               cfg_ready_i
);
  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a sample is in work");

  // a result only appears at the end of a busy stretch
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised without a sample in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("stalled result dropped or changed");

  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config channel blocked");
endmodule

bind imu_dead_reckoning_zupt idr_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload),
  .cfg_ready_i   (cfg_i.ready)
);

/* tb/sv/idr_nav_checker.sv */
`timescale 1ns / 100ps

module idr_nav_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  idr_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  idr_pkg::out_item_t out_item_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  idr_pkg::cfg_item_t cfg_item_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [14:0] acc_low_q, acc_high_q, gyro_lim_q;
  logic [7:0]  quiet_frames_q;
  logic [15:0] bias_gain_q, leak_rate_q;
  logic [7:0]  quiet_cnt_q;
  logic signed [31:0] bias_x_q, bias_y_q, vel_x_q, vel_y_q, pos_x_q, pos_y_q;
  idr_pkg::out_item_t nav_expected_q[$];

  assign pending_o = nav_expected_q.size();

  function automatic logic signed [63:0] round_shr(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // rounds to nearest, ties away from zero
  function automatic logic signed [63:0] scale_ms(input logic signed [63:0] v,
                                                  input logic signed [63:0] ms);
    logic signed [63:0] p;
    p = v * ms;
    return (p >= 0) ? (p + 500) / 1000 : (p - 500) / 1000;
  endfunction

  task automatic predict_nav(input idr_pkg::in_item_t s);
    logic signed [63:0] dt, af, al, au, ra, rb, rc, w, x, y, z;
    logic signed [63:0] r00, r01, r02, r10, r11, r12, axq, ayq, ax, ay, k;
    logic [63:0] sa, sg, lo, hi, gl;
    logic quiet, still;
    idr_pkg::out_item_t e;
    dt = s.elapsed_ms;
    af = s.acc_fwd; al = s.acc_left; au = s.acc_up;
    ra = s.rate_a; rb = s.rate_b; rc = s.rate_c;
    w = s.quat_w; x = s.quat_x; y = s.quat_y; z = s.quat_z;
    if (dt == 0) dt = 5;
    if (dt > 50) dt = 50;
    r00 = idr_pkg::ONE_Q28 - 2 * (y * y + z * z);
    r01 = 2 * (x * y - w * z);
    r02 = 2 * (x * z + w * y);
    r10 = 2 * (x * y + w * z);
    r11 = idr_pkg::ONE_Q28 - 2 * (x * x + z * z);
    r12 = 2 * (y * z - w * x);
    axq = round_shr(r00 * af + r01 * al + r02 * au, 16);
    ayq = round_shr(r10 * af + r11 * al + r12 * au, 16);
    ax = clamp32(round_shr(axq * 64'sd642689, 24));
    ay = clamp32(round_shr(ayq * 64'sd642689, 24));
    sa = af * af + al * al + au * au;
    sg = ra * ra + rb * rb + rc * rc;
    lo = acc_low_q * acc_low_q;
    hi = acc_high_q * acc_high_q;
    gl = (64'(gyro_lim_q) * gyro_lim_q) << 16;
    quiet = (sa > lo) && (sa < hi) && (sg * 64'd1308322 < gl);
    if (quiet) begin
      if (quiet_cnt_q < quiet_frames_q) quiet_cnt_q++;
    end else begin
      quiet_cnt_q = 0;
    end
    still = quiet_cnt_q >= quiet_frames_q;
    if (still) begin
      bias_x_q = clamp32(bias_x_q + round_shr($signed({48'd0, bias_gain_q}) * (ax - bias_x_q), 16));
      bias_y_q = clamp32(bias_y_q + round_shr($signed({48'd0, bias_gain_q}) * (ay - bias_y_q), 16));
      k = 65536 - ($signed({48'd0, leak_rate_q}) * dt * 256 + 500) / 1000;
      if (k < 0) k = 0;
      vel_x_q = clamp32(round_shr(64'(vel_x_q) * k, 16));
      vel_y_q = clamp32(round_shr(64'(vel_y_q) * k, 16));
    end
    ax = ax - bias_x_q;
    ay = ay - bias_y_q;
    vel_x_q = clamp32(64'(vel_x_q) - scale_ms(ax, dt));
    vel_y_q = clamp32(64'(vel_y_q) + scale_ms(ay, dt));
    pos_x_q = clamp32(64'(pos_x_q) - scale_ms(64'(vel_x_q), dt));
    pos_y_q = clamp32(64'(pos_y_q) + scale_ms(64'(vel_y_q), dt));
    e.pos_x = pos_x_q; e.pos_y = pos_y_q;
    e.vel_x = vel_x_q; e.vel_y = vel_y_q;
    e.is_still = still;
    nav_expected_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    idr_pkg::out_item_t e;
    if (!rst_ni) begin
      acc_low_q <= idr_pkg::RST_ACC_LOW; acc_high_q <= idr_pkg::RST_ACC_HIGH;
      gyro_lim_q <= idr_pkg::RST_GYRO_LIM;
      quiet_frames_q <= idr_pkg::RST_QUIET_FRAMES; bias_gain_q <= idr_pkg::RST_BIAS_GAIN;
      leak_rate_q <= idr_pkg::RST_LEAK_RATE;
      quiet_cnt_q = 0; bias_x_q = 0; bias_y_q = 0;
      vel_x_q = 0; vel_y_q = 0; pos_x_q = 0; pos_y_q = 0;
      nav_expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (idr_pkg::reg_e'(cfg_item_i.addr))
          idr_pkg::REG_ACC_LOW:      acc_low_q <= cfg_item_i.data[14:0];
          idr_pkg::REG_ACC_HIGH:     acc_high_q <= cfg_item_i.data[14:0];
          idr_pkg::REG_GYRO_LIM:     gyro_lim_q <= cfg_item_i.data[14:0];
          idr_pkg::REG_QUIET_FRAMES: quiet_frames_q <= cfg_item_i.data[7:0];
          idr_pkg::REG_BIAS_GAIN:    bias_gain_q <= cfg_item_i.data;
          idr_pkg::REG_LEAK_RATE:    leak_rate_q <= cfg_item_i.data;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_nav(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (nav_expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = nav_expected_q.pop_front();
          if (e.pos_x !== out_item_i.pos_x || e.pos_y !== out_item_i.pos_y ||
              e.vel_x !== out_item_i.vel_x || e.vel_y !== out_item_i.vel_y ||
              e.is_still !== out_item_i.is_still) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, out_item_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/imu_dead_reckoning_zupt_tb.sv */
`timescale 1ns / 100ps

module imu_dead_reckoning_zupt_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  bit   idle_free;
  bit   sink_hold;

  idr_stream_if #(.T(idr_pkg::in_item_t))  in_if ();
  idr_stream_if #(.T(idr_pkg::out_item_t)) out_if ();
  idr_stream_if #(.T(idr_pkg::cfg_item_t)) cfg_if ();

  always #2 clk_i = ~clk_i;

  imu_dead_reckoning_zupt u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  idr_nav_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_item_i   (in_if.payload),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_i  (out_if.payload),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_item_i  (cfg_if.payload),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    out_if.ready = 1'b0;
  end

  // result side: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (sink_hold) out_if.ready <= 1'b0;
    else out_if.ready <= idle_free || ($urandom_range(99) >= 10);
  end

  task automatic write_reg(input idr_pkg::reg_e idx, input logic [15:0] val);
    cfg_if.payload <= '{addr: idx, data: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays up after the transaction; the drain lowers it, the next call may too
  task automatic send_sample(input idr_pkg::in_item_t s);
    while (!idle_free && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.payload <= s;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] quat_part(input bit wide);
    return wide ? 16'($signed($urandom_range(32768)) - 16384)
                : 16'($signed($urandom_range(400)) - 200);
  endfunction

  // mostly near 1 g and low rotation, upright attitude; some noise
  function automatic idr_pkg::in_item_t rand_sample(input bit quiet);
    idr_pkg::in_item_t s;
    s.elapsed_ms = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(60));
    if (quiet) begin
      s.acc_fwd  = 16'($signed($urandom_range(200)) - 100);
      s.acc_left = 16'($signed($urandom_range(200)) - 100);
      s.acc_up   = 16'($signed($urandom_range(600)) + 3800);
      s.rate_a   = 16'($signed($urandom_range(100)) - 50);
      s.rate_b   = 16'($signed($urandom_range(100)) - 50);
      s.rate_c   = 16'($signed($urandom_range(100)) - 50);
      s.quat_w   = 16'sd16384 - 16'($urandom_range(300));
      s.quat_x   = quat_part(0); s.quat_y = quat_part(0); s.quat_z = quat_part(0);
    end else begin
      s.acc_fwd = 16'($urandom); s.acc_left = 16'($urandom); s.acc_up = 16'($urandom);
      s.rate_a = 16'($urandom); s.rate_b = 16'($urandom); s.rate_c = 16'($urandom);
      s.quat_w = quat_part(1); s.quat_x = quat_part(1);
      s.quat_y = quat_part(1); s.quat_z = quat_part(1);
    end
    return s;
  endfunction

  initial begin
    idr_pkg::in_item_t s;
    int n;
    idle_free = 1'b0;
    sink_hold = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, time clamping, quiet runs, odd quaternions
    s = '{elapsed_ms: 16'd0, acc_fwd: 16'sh7fff, acc_left: 16'sh8000, acc_up: 16'sh7fff,
          rate_a: 16'sh8000, rate_b: 16'sh7fff, rate_c: 16'sh8000, quat_w: 16'sd16384,
          quat_x: -16'sd16384, quat_y: 16'sd16384, quat_z: -16'sd16384};
    send_sample(s);
    s.elapsed_ms = 16'hffff; s.acc_fwd = 16'sh8000; s.acc_left = 16'sh7fff;
    s.acc_up = 16'sh8000; s.rate_a = 16'sh7fff; s.quat_w = -16'sd16384;
    send_sample(s);
    s.elapsed_ms = 16'd51; send_sample(s);
    s.elapsed_ms = 16'd50; s.quat_w = 16'sd0; s.quat_x = 16'sd0;
    s.quat_y = 16'sd0; s.quat_z = 16'sd0; send_sample(s);
    s = '{elapsed_ms: 16'd1, acc_fwd: 16'sd0, acc_left: 16'sd0, acc_up: 16'sd4096,
          rate_a: 16'sd0, rate_b: 16'sd0, rate_c: 16'sd0, quat_w: 16'sd16384,
          quat_x: 16'sd0, quat_y: 16'sd0, quat_z: 16'sd0};
    send_sample(s);
    drain_results();
    write_reg(idr_pkg::REG_QUIET_FRAMES, 16'd2);
    write_reg(idr_pkg::REG_LEAK_RATE, 16'hffff);
    for (int i = 0; i < 6; i++) begin
      s = rand_sample(1'b1);
      send_sample(s);
    end
    drain_results();
    write_reg(idr_pkg::REG_QUIET_FRAMES, 16'd0);
    write_reg(idr_pkg::REG_BIAS_GAIN, 16'hffff);
    write_reg(idr_pkg::REG_ACC_LOW, 16'h7fff);
    write_reg(idr_pkg::REG_ACC_HIGH, 16'h0000);
    write_reg(idr_pkg::REG_GYRO_LIM, 16'h0000);
    for (int i = 0; i < 4; i++) send_sample(rand_sample(i[0]));
    drain_results();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(idr_pkg::REG_ACC_LOW,
                (ph == 5) ? 16'h7fff : 16'($urandom_range(3000, 3900)));
      write_reg(idr_pkg::REG_ACC_HIGH,
                (ph == 4) ? 16'h7fff : 16'($urandom_range(4300, 5000)));
      write_reg(idr_pkg::REG_GYRO_LIM,
                (ph == 4) ? 16'h7fff : 16'($urandom_range(300, 2000)));
      write_reg(idr_pkg::REG_QUIET_FRAMES,
                (ph == 3) ? 16'd255 : 16'($urandom_range(1, 12)));
      write_reg(idr_pkg::REG_BIAS_GAIN, (ph == 2) ? 16'd0 : 16'($urandom));
      write_reg(idr_pkg::REG_LEAK_RATE, (ph == 1) ? 16'd0 : 16'($urandom_range(4000)));
      idle_free = (ph == 2);
      n = 0;
      while (n < 250) begin
        // bursts of quiet samples with an occasional disturbance
        s = rand_sample($urandom_range(99) < 85);
        send_sample(s);
        n++;
        if (ph == 1 && n == 100) sink_hold = 1'b1;
      end
      drain_results();
    end
    idle_free = 1'b0;
    drain_results();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // long receiver hold-off while samples keep coming
  initial begin
    wait (sink_hold);
    repeat (3000) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  initial begin
    #8000000;
    $display("status: fail");
    $finish;
  end

endmodule

/* imu_dead_reckoning_zupt.f */
sv/idr_pkg.sv
sv/idr_stream_if.sv
sv/idr_div.sv
sv/idr_ctrl.sv
sv/idr_dp.sv
sv/imu_dead_reckoning_zupt.sv
sv/idr_chk.sv
tb/sv/idr_nav_checker.sv
tb/sv/imu_dead_reckoning_zupt_tb.sv
